// File: sv/pbcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_pkg
// Shared widths, register indexes and divider handshake types for the
// power budget to cluster frequency block.
// ----------------------------------------------------------------------------
package pbcf_pkg;

    localparam int SHARE_W    = 20;
    localparam int SUM_W      = SHARE_W + 1;
    localparam int POWER_W    = 16;
    localparam int FREQ_W     = 24;
    localparam int CORES_W    = 4;
    localparam int LVL_IN_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam int LEVELS_DEF   = 16;
    localparam int CLUSTERS_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DUAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP1  = 3'd4;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_BUDGET = 1'b1;

    typedef struct packed {
        logic               start;
        logic [SHARE_W-1:0] dividend;
        logic [CORES_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SHARE_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: sv/pbcf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_in_if
// Input channel: table write items and budget requests.
// ----------------------------------------------------------------------------
interface pbcf_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic                          cluster_sel;
    logic [pbcf_pkg::LVL_IN_W-1:0] level_index;
    logic [pbcf_pkg::POWER_W-1:0]  entry_power;
    logic [pbcf_pkg::FREQ_W-1:0]   entry_freq;
    logic [pbcf_pkg::SHARE_W-1:0]  budget;

    modport source (
        output valid, func, cluster_sel, level_index, entry_power, entry_freq, budget,
        input  ready
    );
    modport sink (
        input  valid, func, cluster_sel, level_index, entry_power, entry_freq, budget,
        output ready
    );
endinterface

// File: sv/pbcf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_out_if
// Output channel: per-cluster frequency caps and power shares.
// ----------------------------------------------------------------------------
interface pbcf_out_if;
    logic                         valid;
    logic                         ready;
    logic [pbcf_pkg::FREQ_W-1:0]  cluster0_freq;
    logic [pbcf_pkg::FREQ_W-1:0]  cluster1_freq;
    logic [pbcf_pkg::SHARE_W-1:0] cluster0_share;
    logic [pbcf_pkg::SHARE_W-1:0] cluster1_share;
    logic                         below_minimum;

    modport source (
        output valid, cluster0_freq, cluster1_freq, cluster0_share, cluster1_share,
               below_minimum,
        input  ready
    );
    modport sink (
        input  valid, cluster0_freq, cluster1_freq, cluster0_share, cluster1_share,
               below_minimum,
        output ready
    );
endinterface

// File: sv/pbcf_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_table
// Per-level power and frequency table, one write and one registered read
// port.
// ----------------------------------------------------------------------------
module pbcf_table #(
    parameter int DEPTH = pbcf_pkg::LEVELS_DEF * pbcf_pkg::CLUSTERS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [pbcf_pkg::POWER_W-1:0] i_wpower,
    input  logic [pbcf_pkg::FREQ_W-1:0]  i_wfreq,
    input  logic [AW-1:0]                i_raddr,
    output logic [pbcf_pkg::POWER_W-1:0] o_rpower,
    output logic [pbcf_pkg::FREQ_W-1:0]  o_rfreq
);

    logic [pbcf_pkg::POWER_W-1:0] r_power [DEPTH];
    logic [pbcf_pkg::FREQ_W-1:0]  r_freq  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_power[i_waddr] <= i_wpower;
            r_freq[i_waddr]  <= i_wfreq;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rpower <= r_power[i_raddr];
        o_rfreq  <= r_freq[i_raddr];
    end

endmodule

// File: sv/pbcf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_div
// Restoring divider, one quotient bit per cycle: share / core count.
// ----------------------------------------------------------------------------
module pbcf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pbcf_pkg::t_div_req i_req,
    output pbcf_pkg::t_div_rsp o_rsp
);

    localparam int QW    = pbcf_pkg::SHARE_W;
    localparam int DW    = pbcf_pkg::CORES_W;
    localparam int CNT_W = $clog2(QW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [QW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvs;

    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             ge;

    assign rem_sh = {r_rem, r_quo[QW-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW - 1);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[QW-2:0], ge};
                r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: sv/power_budget_to_cluster_freq.sv
`timescale 1ns / 1ps
// One item at a time: the input is ready only in the idle state. A budget request
// runs the 20-step serial divider once per cluster, then walks that cluster's table
// down from its top level through the single read port until a level fits the share.
// Reset restores the configuration defaults; the tables are not cleared.
// ----------------------------------------------------------------------------
// power_budget_to_cluster_freq
// Splits a power budget over one or two CPU clusters and picks a frequency
// cap for each from its per-level power table.
// ----------------------------------------------------------------------------
module power_budget_to_cluster_freq #(
    parameter int LEVELS   = pbcf_pkg::LEVELS_DEF,
    parameter int CLUSTERS = pbcf_pkg::CLUSTERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbcf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pbcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pbcf_in_if.sink                         i_in,
    pbcf_out_if.source                      o_out
);

    localparam int  DEPTH = CLUSTERS * LEVELS;
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int  LW    = $clog2(LEVELS);
    localparam bit  MULTI = (CLUSTERS > 1);
    localparam int  SW    = pbcf_pkg::SHARE_W;
    localparam int  UW    = pbcf_pkg::SUM_W;
    localparam int  CW    = pbcf_pkg::CORES_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAX0   = 4'd1;
    localparam logic [3:0] S_MIN0   = 4'd2;
    localparam logic [3:0] S_MAX1   = 4'd3;
    localparam logic [3:0] S_MIN1   = 4'd4;
    localparam logic [3:0] S_LAST   = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_REM    = 4'd7;
    localparam logic [3:0] S_SHARE  = 4'd8;
    localparam logic [3:0] S_DSTART = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_WADDR  = 4'd11;
    localparam logic [3:0] S_WCMP   = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    function automatic logic [AW-1:0] addr_of(input logic c, input logic [LW-1:0] lv);
        return AW'(int'(c) * LEVELS + int'(lv));
    endfunction

    function automatic logic [LW-1:0] top_lv(input logic [3:0] t);
        if (int'(t) >= LEVELS) begin
            return LW'(LEVELS - 1);
        end
        return LW'(t);
    endfunction

    function automatic logic [SW-1:0] scale(input logic [pbcf_pkg::POWER_W-1:0] p,
                                            input logic [CW-1:0] n);
        return SW'(p) * SW'(n);
    endfunction

    function automatic logic [SW-1:0] sat(input logic [UW-1:0] v);
        return v[UW-1] ? {SW{1'b1}} : v[SW-1:0];
    endfunction

    // configuration
    logic          r_dual;
    logic [CW-1:0] r_n0_raw;
    logic [CW-1:0] r_n1_raw;
    logic [3:0]    r_top0_raw;
    logic [3:0]    r_top1_raw;

    // sequencer
    logic [3:0]    r_state;
    logic          r_c;
    logic          r_mode2;
    logic          r_force;
    logic          r_flag;
    logic [LW-1:0] r_lv;
    logic [SW-1:0] r_q;
    logic [SW-1:0] r_budget;
    logic [SW-1:0] r_max0;
    logic [SW-1:0] r_max1;
    logic [SW-1:0] r_min0;
    logic [SW-1:0] r_min1;
    logic [UW-1:0] r_total;
    logic [UW-1:0] r_minsum;
    logic [SW-1:0] r_room;
    logic [UW-1:0] r_remain;
    logic [SW-1:0] r_s0;
    logic [SW-1:0] r_s1;
    logic [pbcf_pkg::FREQ_W-1:0] r_f0;
    logic [pbcf_pkg::FREQ_W-1:0] r_f1;

    // output register
    logic          r_ov;
    logic [pbcf_pkg::FREQ_W-1:0] r_of0;
    logic [pbcf_pkg::FREQ_W-1:0] r_of1;
    logic [SW-1:0] r_os0;
    logic [SW-1:0] r_os1;
    logic          r_oflag;

    logic [CW-1:0] n0;
    logic [CW-1:0] n1;
    logic [LW-1:0] top0;
    logic [LW-1:0] top1;
    logic [LW-1:0] cur_top;
    logic          in_xfer;
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [AW-1:0] rd_addr;
    logic [pbcf_pkg::POWER_W-1:0] rd_power;
    logic [pbcf_pkg::FREQ_W-1:0]  rd_freq;
    logic          hit;

    pbcf_pkg::t_div_req div_req;
    pbcf_pkg::t_div_rsp div_rsp;

    assign n0      = (r_n0_raw == '0) ? CW'(1) : r_n0_raw;
    assign n1      = (r_n1_raw == '0) ? CW'(1) : r_n1_raw;
    assign top0    = top_lv(r_top0_raw);
    assign top1    = top_lv(r_top1_raw);
    assign cur_top = r_c ? top1 : top0;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    assign tbl_we    = in_xfer && (i_in.func == pbcf_pkg::FUNC_WRITE)
                       && (int'(i_in.cluster_sel) < CLUSTERS)
                       && (int'(i_in.level_index) < LEVELS);
    assign tbl_waddr = AW'(int'(i_in.cluster_sel) * LEVELS + int'(i_in.level_index));

    always_comb begin
        unique case (r_state)
            S_MAX0:  rd_addr = addr_of(1'b0, top0);
            S_MIN0:  rd_addr = addr_of(1'b0, '0);
            S_MAX1:  rd_addr = addr_of(1'b1, top1);
            S_MIN1:  rd_addr = addr_of(1'b1, '0);
            S_WADDR: rd_addr = addr_of(r_c, r_lv);
            default: rd_addr = '0;
        endcase
    end

    pbcf_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (tbl_we),
        .i_waddr  (tbl_waddr),
        .i_wpower (i_in.entry_power),
        .i_wfreq  (i_in.entry_freq),
        .i_raddr  (rd_addr),
        .o_rpower (rd_power),
        .o_rfreq  (rd_freq)
    );

    assign div_req.start    = (r_state == S_DSTART);
    assign div_req.dividend = r_c ? r_s1 : r_s0;
    assign div_req.divisor  = r_c ? n1 : n0;

    pbcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign hit = r_force || (r_lv == '0) || (r_q >= SW'(rd_power));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dual     <= 1'b1;
            r_n0_raw   <= CW'(4);
            r_n1_raw   <= CW'(4);
            r_top0_raw <= 4'd15;
            r_top1_raw <= 4'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbcf_pkg::CFG_DUAL:  r_dual     <= i_cfg_data[0];
                pbcf_pkg::CFG_CORE0: r_n0_raw   <= i_cfg_data;
                pbcf_pkg::CFG_CORE1: r_n1_raw   <= i_cfg_data;
                pbcf_pkg::CFG_TOP0:  r_top0_raw <= i_cfg_data;
                pbcf_pkg::CFG_TOP1:  r_top1_raw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c     <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in.func == pbcf_pkg::FUNC_BUDGET)) begin
                        r_c      <= 1'b0;
                        r_budget <= i_in.budget;
                        r_mode2  <= r_dual && MULTI;
                        r_flag   <= 1'b0;
                        r_s0     <= i_in.budget;
                        r_s1     <= '0;
                        r_f1     <= '0;
                        r_state  <= (r_dual && MULTI) ? S_MAX0 : S_DSTART;
                    end
                end
                S_MAX0: r_state <= S_MIN0;
                S_MIN0: begin
                    r_max0  <= scale(rd_power, n0);
                    r_state <= S_MAX1;
                end
                S_MAX1: begin
                    r_min0  <= scale(rd_power, n0);
                    r_state <= S_MIN1;
                end
                S_MIN1: begin
                    r_max1  <= scale(rd_power, n1);
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    r_min1  <= scale(rd_power, n1);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_total  <= (r_budget == '0) ? (UW'(r_max0) + UW'(r_max1))
                                                 : UW'(r_budget);
                    r_minsum <= UW'(r_min0) + UW'(r_min1);
                    r_room   <= (r_max0 > r_min0) ? (r_max0 - r_min0) : '0;
                    r_state  <= S_REM;
                end
                S_REM: begin
                    r_flag   <= !(r_total > r_minsum);
                    r_remain <= r_total - r_minsum;
                    r_state  <= S_SHARE;
                end
                S_SHARE: begin
                    priority if (r_flag) begin
                        r_s0 <= r_min0;
                        r_s1 <= r_min1;
                    end else if (r_remain <= UW'(r_room)) begin
                        r_s0 <= sat(UW'(r_min0) + r_remain);
                        r_s1 <= r_min1;
                    end else begin
                        r_s0 <= sat(UW'(r_min0) + UW'(r_room));
                        r_s1 <= sat(UW'(r_min1) + (r_remain - UW'(r_room)));
                    end
                    r_state <= S_DSTART;
                end
                S_DSTART: r_state <= S_DIV;
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quotient;
                        r_lv    <= cur_top;
                        r_force <= !r_mode2 && (div_rsp.quotient == '0);
                        r_state <= S_WADDR;
                    end
                end
                S_WADDR: r_state <= S_WCMP;
                S_WCMP: begin
                    if (hit) begin
                        if (r_c) begin
                            r_f1    <= rd_freq;
                            r_state <= S_OUT;
                        end else begin
                            r_f0 <= rd_freq;
                            if (r_mode2) begin
                                r_c     <= 1'b1;
                                r_state <= S_DSTART;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                    end else begin
                        r_lv    <= r_lv - LW'(1);
                        r_state <= S_WADDR;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_of0   <= r_f0;
                        r_of1   <= r_f1;
                        r_os0   <= r_s0;
                        r_os1   <= r_s1;
                        r_oflag <= r_flag;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.cluster0_freq  = r_of0;
    assign o_out.cluster1_freq  = r_of1;
    assign o_out.cluster0_share = r_os0;
    assign o_out.cluster1_share = r_os1;
    assign o_out.below_minimum  = r_oflag;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the wait state");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WCMP) |-> (r_lv <= cur_top))
        else $error("table walk beyond the top level");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_ov && !o_out.ready) |=> (r_state == S_OUT))
        else $error("result overwrote a pending transfer");

    a_single_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && !r_mode2) |-> (!r_flag && (r_s1 == '0) && (r_f1 == '0)))
        else $error("single mode produced cluster 1 fields");
`endif

endmodule
